FILE: src/vcfd_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the velocity
// command frame decoder. No dependencies.
package vcfd_pkg;

	// Frame layout
	localparam int unsigned FRAME_BYTES = 16;
	localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
	localparam int unsigned POS_W       = IDX_W + 1;
	localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_BYTES);

	localparam logic [IDX_W-1:0] POS_START_ONE = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_START_TWO = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_TYPE      = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_LENGTH    = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_MODE      = IDX_W'(12);
	localparam logic [IDX_W-1:0] POS_SEQ       = IDX_W'(13);
	localparam logic [IDX_W-1:0] POS_CRC_LO    = IDX_W'(14);
	localparam logic [IDX_W-1:0] POS_CRC_HI    = IDX_W'(15);
	localparam logic [IDX_W-1:0] POS_CRC_FIRST = POS_TYPE;
	localparam logic [IDX_W-1:0] POS_CRC_LAST  = POS_SEQ;

	localparam logic [7:0]  LEN_VALUE = 8'd10;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Running counters
	localparam int unsigned CNT_W = 32;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ONE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_START_TWO = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_TYPE  = CFG_IDX_W'(2);

	localparam logic [7:0] RST_START_ONE = 8'hAA;
	localparam logic [7:0] RST_START_TWO = 8'h55;
	localparam logic [7:0] RST_CMD_TYPE  = 8'h01;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_SHORT = 3'd1,
		STAT_HDR   = 3'd2,
		STAT_LEN   = 3'd3,
		STAT_CRC   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_HDR  = 2'd1,
		FAULT_LEN  = 2'd2
	} fault_t;

	typedef struct packed {
		logic [7:0] start_one;
		logic [7:0] start_two;
		logic [7:0] cmd_type;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [31:0]      linear;
		logic [31:0]      angular;
		logic [7:0]       mode;
		logic [7:0]       seq;
		logic [CNT_W-1:0] crc_errors;
		logic [CNT_W-1:0] good_frames;
	} result_t;

	// One byte of CRC-16/MODBUS, reflected, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: src/vcfd_cfg_regs.sv
// Configuration registers of the frame decoder: expected start bytes and type.
// Depends on vcfd_pkg.
module vcfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output vcfd_pkg::cfg_t                 cfg
);

	vcfd_pkg::cfg_t cfg_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_one <= vcfd_pkg::RST_START_ONE;
			cfg_q.start_two <= vcfd_pkg::RST_START_TWO;
			cfg_q.cmd_type  <= vcfd_pkg::RST_CMD_TYPE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vcfd_pkg::CFG_START_ONE: cfg_q.start_one <= cfg_data;
				vcfd_pkg::CFG_START_TWO: cfg_q.start_two <= cfg_data;
				vcfd_pkg::CFG_CMD_TYPE:  cfg_q.cmd_type  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: src/vcfd_parser.sv
// Frame parser: byte position, header checks, CRC, field capture and counters.
// Produces at most one result per byte step. Depends on vcfd_pkg.
module vcfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	input  logic                start_in,
	input  logic                last_in,
	input  vcfd_pkg::cfg_t      cfg,
	output vcfd_pkg::result_t   res
);

	logic [vcfd_pkg::POS_W-1:0] pos_q, pos_d, pos_base;
	logic [15:0]                crc_q, crc_d, crc_base;
	vcfd_pkg::fault_t           fault_q, fault_d, fault_base;
	logic [31:0]                linear_q, linear_d;
	logic [31:0]                angular_q, angular_d;
	logic [7:0]                 mode_q, mode_d;
	logic [7:0]                 seq_q, seq_d;
	logic [7:0]                 crc_lo_q, crc_lo_d;
	logic [vcfd_pkg::CNT_W-1:0] crc_err_q, crc_err_d;
	logic [vcfd_pkg::CNT_W-1:0] good_q, good_d;
	logic                       active;
	logic [vcfd_pkg::IDX_W-1:0] p;
	logic [15:0]                rx_crc;

	// A start flag restarts the frame before this byte is looked at
	always_comb begin
		pos_base   = start_in ? '0 : pos_q;
		crc_base   = start_in ? vcfd_pkg::CRC_INIT : crc_q;
		fault_base = start_in ? vcfd_pkg::FAULT_NONE : fault_q;
		active     = !pos_base[vcfd_pkg::POS_W-1];
		p          = pos_base[vcfd_pkg::IDX_W-1:0];
		rx_crc     = {byte_in, crc_lo_q};
	end

	// Next state and result
	always_comb begin
		pos_d     = pos_q;
		crc_d     = crc_q;
		fault_d   = fault_q;
		linear_d  = linear_q;
		angular_d = angular_q;
		mode_d    = mode_q;
		seq_d     = seq_q;
		crc_lo_d  = crc_lo_q;
		crc_err_d = crc_err_q;
		good_d    = good_q;

		res             = '0;
		res.status      = vcfd_pkg::STAT_OK;
		res.crc_errors  = crc_err_q;
		res.good_frames = good_q;

		if (step) begin
			pos_d   = pos_base;
			crc_d   = crc_base;
			fault_d = fault_base;
			if (active) begin
				if (p >= vcfd_pkg::POS_CRC_FIRST && p <= vcfd_pkg::POS_CRC_LAST) begin
					crc_d = vcfd_pkg::crc16_byte(crc_base, byte_in);
				end

				// Header checks and field capture by position
				unique case (p)
					vcfd_pkg::POS_START_ONE: begin
						if (byte_in != cfg.start_one) fault_d = vcfd_pkg::FAULT_HDR;
					end
					vcfd_pkg::POS_START_TWO: begin
						if (byte_in != cfg.start_two) fault_d = vcfd_pkg::FAULT_HDR;
					end
					vcfd_pkg::POS_TYPE: begin
						if (byte_in != cfg.cmd_type) fault_d = vcfd_pkg::FAULT_HDR;
					end
					vcfd_pkg::POS_LENGTH: begin
						if (byte_in != vcfd_pkg::LEN_VALUE && fault_base == vcfd_pkg::FAULT_NONE)
							fault_d = vcfd_pkg::FAULT_LEN;
					end
					4'd4, 4'd5, 4'd6, 4'd7: begin
						linear_d[{p[1:0], 3'b000} +: 8] = byte_in;
					end
					4'd8, 4'd9, 4'd10, 4'd11: begin
						angular_d[{p[1:0], 3'b000} +: 8] = byte_in;
					end
					vcfd_pkg::POS_MODE:   mode_d   = byte_in;
					vcfd_pkg::POS_SEQ:    seq_d    = byte_in;
					vcfd_pkg::POS_CRC_LO: crc_lo_d = byte_in;
					vcfd_pkg::POS_CRC_HI: ;
					default: ;
				endcase

				if (p == vcfd_pkg::POS_CRC_HI) begin
					// Last byte: judge the frame
					pos_d     = vcfd_pkg::POS_IDLE;
					res.valid = 1'b1;
					priority if (fault_base == vcfd_pkg::FAULT_HDR) begin
						res.status = vcfd_pkg::STAT_HDR;
					end else if (fault_base != vcfd_pkg::FAULT_NONE) begin
						res.status = vcfd_pkg::STAT_LEN;
					end else if (rx_crc != crc_base) begin
						crc_err_d  = crc_err_q + 1'b1;
						res.status = vcfd_pkg::STAT_CRC;
					end else begin
						good_d      = good_q + 1'b1;
						res.status  = vcfd_pkg::STAT_OK;
						res.linear  = linear_q;
						res.angular = angular_q;
						res.mode    = mode_q;
						res.seq     = seq_q;
					end
				end else begin
					pos_d = pos_base + 1'b1;
					if (last_in) begin
						// Frame ended early
						pos_d      = vcfd_pkg::POS_IDLE;
						res.valid  = 1'b1;
						res.status = vcfd_pkg::STAT_SHORT;
					end
				end
			end
			res.crc_errors  = crc_err_d;
			res.good_frames = good_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= vcfd_pkg::POS_IDLE;
			crc_q     <= vcfd_pkg::CRC_INIT;
			fault_q   <= vcfd_pkg::FAULT_NONE;
			linear_q  <= '0;
			angular_q <= '0;
			mode_q    <= '0;
			seq_q     <= '0;
			crc_lo_q  <= '0;
			crc_err_q <= '0;
			good_q    <= '0;
		end else begin
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			fault_q   <= fault_d;
			linear_q  <= linear_d;
			angular_q <= angular_d;
			mode_q    <= mode_d;
			seq_q     <= seq_d;
			crc_lo_q  <= crc_lo_d;
			crc_err_q <= crc_err_d;
			good_q    <= good_d;
		end
	end

`ifndef SYNTHESIS
	// Position never goes past idle
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= vcfd_pkg::POS_IDLE)
		else $error("byte position out of range");

	// Error and good counts never move together
	a_count_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((crc_err_q != $past(crc_err_q)) && (good_q != $past(good_q))))
		else $error("both counters moved at once");

	// Good count only steps by one, and only with an ok result
	a_good_step: assert property (@(posedge clk) disable iff (!arst_n)
		(good_d != good_q) |-> (res.valid && res.status == vcfd_pkg::STAT_OK
			&& good_d == good_q + 1'b1))
		else $error("good frame count stepped without an ok result");
`endif

endmodule

FILE: src/velocity_command_frame_decoder.sv
// Velocity command frame decoder, top level: input register, parser, result register.
// Depends on vcfd_pkg, vcfd_cfg_regs and vcfd_parser.
//
// Usage:
//   Frame bytes enter on the s_ stream, one word per byte: s_tdata is the byte,
//   s_tuser flags byte 0 of a new frame (restarts parsing), s_tlast marks the
//   last byte the sender supplies. One result word per 16-byte frame, or per
//   frame cut short by s_tlast, leaves on the m_ stream; bytes past the 16th
//   and bytes outside a frame are dropped.
//   The cfg_ channel writes the two start bytes and the command type; write
//   only while no frame is in flight.
// Timing:
//   A byte is registered at acceptance and judged from the input register once the
//   result register is free; the result of a frame is then registered in the result
//   register, which drives m_tvalid until the result is taken.
//   One byte per cycle is sustained unless a result stalls: the CRC step, header checks
//   and field capture are a single byte-wide pass between the input and result registers.
// Reset empties the input and result registers, clears the parser state, restores
// the register defaults (AA, 55, 01) and zeroes the counters. When the receiver
// stalls a pending result, one more byte is held in the input register and s_tready drops.
module velocity_command_frame_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] frame_byte
	input  logic                           s_tuser,   // [0] frame_start
	input  logic                           s_tlast,   // frame_end
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [143:0]                   m_tdata,   // [31:0] linear_bits, [63:32] angular_bits,
	                                                  // [71:64] mode, [79:72] sequence_res,
	                                                  // [111:80] crc_errors, [143:112] good_frames
	output logic [2:0]                     m_tuser,   // [2:0] status
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	vcfd_pkg::cfg_t    cfg;
	vcfd_pkg::result_t res;
	vcfd_pkg::result_t res_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       last_s1;
	logic       m_valid_s2;
	logic       advance;
	logic       step;

	vcfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Flow control: the held byte moves on when the result register is free
	assign advance  = !m_valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	vcfd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.start_in (start_s1),
		.last_in  (last_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (advance) begin
			m_valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = m_valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {res_s2.good_frames, res_s2.crc_errors, res_s2.seq, res_s2.mode,
		res_s2.angular, res_s2.linear};

`ifndef SYNTHESIS
	// A byte blocked by a pending result stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input register lost a byte under stall");

	// The input side only stalls behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_s2 && !m_tready))
		else $error("input stalled without a stalled result");

	// A new result always comes from a byte that was held in the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a byte step");
`endif

endmodule
